/* rtl/shrp3x3_pkg.sv */
`default_nettype none

package shrp3x3_pkg;

  typedef struct packed {
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_row;
    logic [11:0] out_col;
    logic [7:0]  out_blue;
    logic [7:0]  out_green;
    logic [7:0]  out_red;
    logic [7:0]  out_alpha;
    logic        last;
  } out_item_t;

  // Register map, selected by paddr[2]
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;
  localparam int   PADDR_W          = 3;

  localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd480;

  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0]  PX_MAX       = 8'd255;
  localparam logic [12:0] CENTER_GAIN  = 13'd9;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;

  // 9*center minus the neighbor sum, clamped to 0..255
  function automatic logic [7:0] sharpen_px(input logic [7:0] center,
                                            input logic [10:0] nsum);
    logic [12:0] acc;
    acc = 13'(center) * CENTER_GAIN - 13'(nsum);
    if (acc[12]) begin
      return 8'd0;
    end else if (acc[11:8] != 4'd0) begin
      return PX_MAX;
    end else begin
      return acc[7:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/shrp3x3_line_buf.sv */
`default_nettype none

module shrp3x3_line_buf import shrp3x3_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [23:0]   wr_px_i,
  output logic      [23:0]   up_o,
  output logic      [23:0]   mid_o
);

  logic [23:0] upper_mem  [MAX_WIDTH];
  logic [23:0] middle_mem [MAX_WIDTH];

  logic [23:0] up_rd_q, mid_rd_q;
  logic [23:0] fwd_up_q, fwd_mid_q;
  logic        fwd_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      up_rd_q  <= upper_mem[rd_addr_i];
      mid_rd_q <= middle_mem[rd_addr_i];
    end
    // Rotate the column: middle moves up, the new pixel becomes middle
    if (wr_en_i) begin
      upper_mem[wr_addr_i]  <= mid_o;
      middle_mem[wr_addr_i] <= wr_px_i;
    end
    fwd_up_q  <= mid_o;
    fwd_mid_q <= wr_px_i;
  end

  // Read of the entry being written in the same cycle takes the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (rd_addr_i == wr_addr_i);
    end
  end

  assign up_o  = fwd_q ? fwd_up_q  : up_rd_q;
  assign mid_o = fwd_q ? fwd_mid_q : mid_rd_q;

endmodule

`default_nettype wire

/* rtl/shrp3x3_out_fifo.sv */
`default_nettype none

module shrp3x3_out_fifo import shrp3x3_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_first_i,
  input  wire out_item_t             first_i,
  input  wire logic                  push_second_i,
  input  wire out_item_t             second_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output out_item_t                  item_o,
  output logic [FIFO_CNT_W-1:0]      count_o
);

  out_item_t slots_q [FIFO_DEPTH];

  logic [FIFO_PTR_W-1:0] wr_q, rd_q, wr_next1;
  logic [FIFO_CNT_W-1:0] count_q;
  logic                  pop;

  assign wr_next1 = wr_q + FIFO_PTR_W'(1);
  assign valid_o  = (count_q != '0);
  assign pop      = valid_o && ready_i;
  assign item_o   = slots_q[rd_q];
  assign count_o  = count_q;

  always_ff @(posedge clk_i) begin
    if (push_first_i) begin
      slots_q[wr_q] <= first_i;
    end
    if (push_second_i) begin
      slots_q[wr_next1] <= second_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + FIFO_PTR_W'(push_first_i) + FIFO_PTR_W'(push_second_i);
      rd_q    <= rd_q + FIFO_PTR_W'(pop);
      count_q <= count_q + FIFO_CNT_W'(push_first_i) + FIFO_CNT_W'(push_second_i)
                 - FIFO_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

/* rtl/sharpen_3x3_convolution_top.sv */
`default_nettype none

// Channel  Direction  Payload     Handshake
// in       input      in_item_t   in_valid_i / in_ready_o
// out      output     out_item_t  out_valid_o / out_ready_i
// cfg      input      APB write   psel & penable & pwrite & pready
//
// One pixel per cycle while the FIFO has room; results pass stage 1, then the FIFO.
// The line-store read-modify-write loop sets the rate: read at accept, write back
// and convolve in the next cycle. Up to two results per pixel queue in an 8-entry
// output FIFO; input stalls unless that FIFO has room for two results from the pixel
// in stage 1 and two from the next one, so the last image row, where most pixels
// emit two results, runs at the output rate.
// Reset clears counters, window and registers; line stores hold old data.

module sharpen_3x3_convolution_top import shrp3x3_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_item_t           in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_item_t               out_item_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int CW = $clog2(MAX_WIDTH);

  // Configuration
  logic [12:0] image_width_q;
  logic [15:0] image_height_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= IMAGE_WIDTH_RST;
      image_height_q <= IMAGE_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_IMAGE_WIDTH:  image_width_q  <= pwdata[12:0];
        REG_IMAGE_HEIGHT: image_height_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = {19'd0, image_width_q};
      REG_IMAGE_HEIGHT: prdata = {16'd0, image_height_q};
      default:          prdata = '0;
    endcase
  end

  // Position of the accepted pixel
  logic [CW-1:0] col_q, w_last, x_cur;
  logic [15:0]   row_q, h_last, y_cur;
  logic          in_accept, is_int, is_bord;

  assign in_accept = in_valid_i && in_ready_o;

  always_comb begin
    if (image_width_q < 13'd3) begin
      w_last = CW'(2);
    end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(image_width_q - 13'd1);
    end
    h_last  = (image_height_q < 16'd3) ? 16'd2 : image_height_q - 16'd1;
    x_cur   = (col_q > w_last) ? w_last : col_q;
    y_cur   = (row_q > h_last) ? h_last : row_q;
    is_int  = (y_cur >= 16'd2) && (32'(x_cur) >= 32'd2);
    is_bord = (y_cur == 16'd0) || (y_cur == h_last) || (x_cur == '0) || (x_cur == w_last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_accept) begin
      if (x_cur >= w_last) begin
        col_q <= '0;
        row_q <= (y_cur >= h_last) ? 16'd0 : y_cur + 16'd1;
      end else begin
        col_q <= x_cur + CW'(1);
      end
    end
  end

  // Stage 1: line-store data arrives, window shifts, kernel runs
  logic          s1_valid_q, s1_int_q, s1_bord_q;
  logic [23:0]   s1_px_q;
  logic [CW-1:0] s1_x_q;
  logic [15:0]   s1_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_int_q   <= 1'b0;
      s1_bord_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
      s1_int_q   <= in_accept && is_int;
      s1_bord_q  <= in_accept && is_bord;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_px_q <= {in_item_i.in_red, in_item_i.in_green, in_item_i.in_blue};
      s1_x_q  <= x_cur;
      s1_y_q  <= y_cur;
    end
  end

  logic [23:0] lb_up, lb_mid;

  shrp3x3_line_buf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_addr_i (x_cur),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_x_q),
    .wr_px_i   (s1_px_q),
    .up_o      (lb_up),
    .mid_o     (lb_mid)
  );

  logic [23:0] win_q [3][3];
  logic [23:0] win_d [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = lb_up;
    win_d[1][2] = lb_mid;
    win_d[2][2] = s1_px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (s1_valid_q) begin
      win_q <= win_d;
    end
  end

  logic [7:0]  sharp [3];
  logic [10:0] nsum  [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      nsum[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (!(r == 1 && c == 1)) begin
            nsum[ch] = nsum[ch] + 11'(win_d[r][c][ch*8 +: 8]);
          end
        end
      end
      sharp[ch] = sharpen_px(win_d[1][1][ch*8 +: 8], nsum[ch]);
    end
  end

  out_item_t   int_item, bord_item, first_item;
  logic [31:0] int_col32, bord_col32;

  always_comb begin
    int_col32  = 32'(s1_x_q - CW'(1));
    bord_col32 = 32'(s1_x_q);

    int_item.out_row   = s1_y_q - 16'd1;
    int_item.out_col   = int_col32[11:0];
    int_item.out_blue  = sharp[0];
    int_item.out_green = sharp[1];
    int_item.out_red   = sharp[2];
    int_item.out_alpha = ALPHA_OPAQUE;
    int_item.last      = !s1_bord_q;

    bord_item.out_row   = s1_y_q;
    bord_item.out_col   = bord_col32[11:0];
    bord_item.out_blue  = 8'd0;
    bord_item.out_green = 8'd0;
    bord_item.out_red   = 8'd0;
    bord_item.out_alpha = ALPHA_OPAQUE;
    bord_item.last      = 1'b1;

    first_item = s1_int_q ? int_item : bord_item;
  end

  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W:0]   fifo_need;

  shrp3x3_out_fifo u_out_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_first_i  (s1_int_q || s1_bord_q),
    .first_i       (first_item),
    .push_second_i (s1_int_q && s1_bord_q),
    .second_i      (bord_item),
    .valid_o       (out_valid_o),
    .ready_i       (out_ready_i),
    .item_o        (out_item_o),
    .count_o       (fifo_count)
  );

  // Reserve room for the pixel in stage 1 and the one about to be accepted
  assign fifo_need  = {1'b0, fifo_count} + (s1_valid_q ? (FIFO_CNT_W+1)'(2) : '0);
  assign in_ready_o = fifo_need <= (FIFO_CNT_W+1)'(FIFO_DEPTH - 2);

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fifo_count) <= 32'(FIFO_DEPTH))
    else $error("output FIFO overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |-> fifo_count >= (FIFO_CNT_W)'(2))
    else $error("first of a result pair queued without its partner");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (x_cur == w_last) |=> col_q == '0)
    else $error("column counter did not wrap at row end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_int_q || s1_bord_q) |-> s1_valid_q)
    else $error("result flags set without a pixel in stage 1");

endmodule

`default_nettype wire

/* tb/sharpen_3x3_convolution_top_tb.sv */
module sharpen_3x3_convolution_top_tb import shrp3x3_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_DEPTH = 4096;
  // Columns below this count hold known line data after the warm-up frame
  localparam int WARM_COLS  = 64;

  class pixel_scoreboard;
    logic [12:0] width_reg;
    logic [15:0] height_reg;
    logic [23:0] upper_line [LINE_DEPTH];
    logic [23:0] middle_line [LINE_DEPTH];
    logic [23:0] win [3][3];
    int unsigned row_pos;
    int unsigned col_pos;
    out_item_t   due_pixels[$];
    int unsigned errors;
    int unsigned pixels;
    int unsigned results;
    int unsigned sharpened;
    int unsigned borders;
    int unsigned w_min = LINE_DEPTH;
    int unsigned w_max;
    int unsigned h_min = 65535;
    int unsigned h_max;

    function new();
      width_reg  = IMAGE_WIDTH_RST;
      height_reg = IMAGE_HEIGHT_RST;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win[r, c]) begin
        win[r][c] = '0;
      end
    endfunction

    function int unsigned eff_width();
      if (width_reg < 3) return 3;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg < 3) ? 3 : height_reg;
    endfunction

    function void write_reg(logic reg_sel, logic [31:0] wdata);
      if (reg_sel == REG_IMAGE_WIDTH) begin
        width_reg = wdata[12:0];
      end else begin
        height_reg = wdata[15:0];
      end
    endfunction

    function logic [31:0] reg_value(logic reg_sel);
      return (reg_sel == REG_IMAGE_WIDTH) ? 32'(width_reg) : 32'(height_reg);
    endfunction

    // 9 * center minus the eight neighbors of one channel, clamped to a byte
    function logic [7:0] filtered(int sh);
      int acc;
      int v;
      acc = 0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          v = win[r][c][sh +: 8];
          acc += (r == 1 && c == 1) ? 9 * v : -v;
        end
      end
      if (acc < 0) return 8'd0;
      if (acc > 255) return 8'd255;
      return acc[7:0];
    endfunction

    function void accept_pixel(in_item_t px);
      int unsigned w;
      int unsigned h;
      int unsigned x;
      int unsigned y;
      logic [23:0] up;
      logic [23:0] mid;
      logic [23:0] cur;
      logic        on_border;
      out_item_t   res;
      w = eff_width();
      h = eff_height();
      if (w < w_min) w_min = w;
      if (w > w_max) w_max = w;
      if (h < h_min) h_min = h;
      if (h > h_max) h_max = h;
      // pull counters back inside a frame that shrank
      if (col_pos > w - 1) col_pos = w - 1;
      if (row_pos > h - 1) row_pos = h - 1;
      x = col_pos;
      y = row_pos;
      pixels++;

      cur = {px.in_red, px.in_green, px.in_blue};
      up  = upper_line[x];
      mid = middle_line[x];
      upper_line[x]  = mid;
      middle_line[x] = cur;
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = cur;

      on_border = (y == 0) || (y == h - 1) || (x == 0) || (x == w - 1);
      if (y >= 2 && x >= 2) begin
        res.out_row   = 16'(y - 1);
        res.out_col   = 12'(x - 1);
        res.out_blue  = filtered(0);
        res.out_green = filtered(8);
        res.out_red   = filtered(16);
        res.out_alpha = ALPHA_OPAQUE;
        res.last      = !on_border;
        due_pixels.push_back(res);
        sharpened++;
      end
      if (on_border) begin
        res.out_row   = 16'(y);
        res.out_col   = 12'(x);
        res.out_blue  = 8'd0;
        res.out_green = 8'd0;
        res.out_red   = 8'd0;
        res.out_alpha = ALPHA_OPAQUE;
        res.last      = 1'b1;
        due_pixels.push_back(res);
        borders++;
      end

      if (x >= w - 1) begin
        col_pos = 0;
        row_pos = (y >= h - 1) ? 0 : y + 1;
      end else begin
        col_pos = x + 1;
      end
    endfunction

    function void compare_field(string name, out_item_t want, logic [15:0] exp_v,
                                logic [15:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s at (%0d,%0d): expected %0d, got %0d", $time, name,
                 want.out_row, want.out_col, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_out_pixel(out_item_t got);
      out_item_t want;
      if (due_pixels.size() == 0) begin
        $display("%0t: unexpected item, expected none, got row %0d col %0d", $time,
                 got.out_row, got.out_col);
        errors++;
        return;
      end
      want = due_pixels.pop_front();
      results++;
      compare_field("out_row", want, want.out_row, got.out_row);
      compare_field("out_col", want, 16'(want.out_col), 16'(got.out_col));
      compare_field("out_blue", want, 16'(want.out_blue), 16'(got.out_blue));
      compare_field("out_green", want, 16'(want.out_green), 16'(got.out_green));
      compare_field("out_red", want, 16'(want.out_red), 16'(got.out_red));
      compare_field("out_alpha", want, 16'(want.out_alpha), 16'(got.out_alpha));
      compare_field("last", want, 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_item_t           in_item_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_item_t          out_item_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  pixel_scoreboard sb;
  int unsigned     tx_max_gap    = 8;
  int unsigned     rx_max_wait   = 8;
  int unsigned     rx_hold_cycles;
  int unsigned     long_holds;
  int unsigned     cfg_writes;

  sharpen_3x3_convolution_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #6 clk_i = ~clk_i;

  task automatic cfg_access(input logic write_en, input logic reg_sel,
                            input logic [31:0] wdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_en;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (write_en) begin
      sb.write_reg(reg_sel, wdata);
      cfg_writes++;
    end else if (prdata !== sb.reg_value(reg_sel)) begin
      $display("%0t: register %0d read back: expected %0d, got %0d", $time, reg_sel,
               sb.reg_value(reg_sel), prdata);
      sb.errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write with junk above the register width, then read it back
  task automatic set_reg(input logic reg_sel, input int unsigned value);
    logic [31:0] mask;
    mask = (reg_sel == REG_IMAGE_WIDTH) ? 32'h0000_1FFF : 32'h0000_FFFF;
    cfg_access(1'b1, reg_sel, ($urandom() & ~mask) | (value & mask));
    cfg_access(1'b0, reg_sel, 32'd0);
  endtask

  task automatic send_pixel(input in_item_t px);
    int unsigned gap;
    gap = $urandom_range(0, tx_max_gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item_i  <= px;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.accept_pixel(px);
  endtask

  // Drop valid, wait for every due item, then let the line-store write-back settle
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.due_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [7:0] near_level(int base);
    int v;
    v = base + int'($urandom_range(0, 24)) - 12;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic in_item_t next_pixel(int base_b, int base_g, int base_r);
    in_item_t px;
    case ($urandom_range(0, 5))
      0: begin
        px = in_item_t'(24'($urandom()));
      end
      1: begin
        px.in_blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        px.in_green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        px.in_red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      default: begin
        px.in_blue  = near_level(base_b);
        px.in_green = near_level(base_g);
        px.in_red   = near_level(base_r);
      end
    endcase
    return px;
  endfunction

  initial begin : rx_side
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        hold = rx_hold_cycles;
        rx_hold_cycles = 0;
        long_holds++;
      end else begin
        hold = $urandom_range(0, rx_max_wait);
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_out_pixel(out_item_o);
    end
  end

  initial begin : stimulus
    in_item_t    px;
    int unsigned n;
    int unsigned room;
    int unsigned phase;
    int unsigned rand_pixels;
    int unsigned w_raw;
    int unsigned h_raw;
    int unsigned which;
    int          base_b;
    int          base_g;
    int          base_r;
    sb = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    cfg_access(1'b0, REG_IMAGE_WIDTH, 32'd0);
    cfg_access(1'b0, REG_IMAGE_HEIGHT, 32'd0);

    // Smallest frame: one sharpened pixel, saturating high, low and in range
    set_reg(REG_IMAGE_WIDTH, 3);
    set_reg(REG_IMAGE_HEIGHT, 3);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) begin
        px.in_blue  = 8'd255;
        px.in_green = 8'd0;
        px.in_red   = 8'd30;
      end else begin
        px.in_blue  = 8'd0;
        px.in_green = 8'd255;
        px.in_red   = 8'd20;
      end
      send_pixel(px);
    end
    wait_idle();

    set_reg(REG_IMAGE_WIDTH, 4);
    set_reg(REG_IMAGE_HEIGHT, 4);
    for (int i = 0; i < 16; i++) begin
      px.in_blue  = (i % 2 != 0) ? 8'd255 : 8'd0;
      px.in_green = 8'(i * 17);
      px.in_red   = 8'(255 - i * 13);
      send_pixel(px);
    end
    wait_idle();

    // Warm-up frame: fill both line stores over the columns used from here on
    set_reg(REG_IMAGE_WIDTH, WARM_COLS);
    set_reg(REG_IMAGE_HEIGHT, 4);
    base_b = $urandom_range(0, 255);
    base_g = $urandom_range(0, 255);
    base_r = $urandom_range(0, 255);
    for (int i = 0; i < 2 * WARM_COLS; i++) begin
      send_pixel(next_pixel(base_b, base_g, base_r));
    end
    rand_pixels = 2 * WARM_COLS;

    phase = 0;
    while (rand_pixels < 900) begin
      wait_idle();
      base_b = $urandom_range(0, 255);
      base_g = $urandom_range(0, 255);
      base_r = $urandom_range(0, 255);
      tx_max_gap  = ($urandom_range(0, 3) == 0) ? 0 : 8;
      rx_max_wait = ($urandom_range(0, 3) == 0) ? 0 : 8;
      n = $urandom_range(20, 100);
      if (phase == 0) begin
        n = 60;
      end else begin
        case ($urandom_range(0, 9))
          0:       w_raw = 3;
          1:       w_raw = $urandom_range(0, 2);
          2:       w_raw = WARM_COLS;
          3:       w_raw = LINE_DEPTH;
          4:       w_raw = $urandom_range(LINE_DEPTH + 1, 8191);
          5, 6:    w_raw = $urandom_range(3, 12);
          default: w_raw = $urandom_range(3, WARM_COLS);
        endcase
        case ($urandom_range(0, 7))
          0:       h_raw = 3;
          1:       h_raw = $urandom_range(0, 2);
          2:       h_raw = 65535;
          3, 4:    h_raw = $urandom_range(3, 8);
          default: h_raw = $urandom_range(3, 24);
        endcase
        which = $urandom_range(0, 3);
        if (which == 1 || which == 3) set_reg(REG_IMAGE_WIDTH, w_raw);
        if (which == 2 || which == 3) set_reg(REG_IMAGE_HEIGHT, h_raw);
        // keep wide rows inside the columns whose line data is known
        if (sb.eff_width() > WARM_COLS) begin
          room = (sb.col_pos < WARM_COLS) ? WARM_COLS - sb.col_pos : 0;
          if (n > room) n = room;
        end
      end
      // Hold the output off long enough for the block to back up into its input
      if (phase == 0 || $urandom_range(0, 7) == 0) begin
        tx_max_gap = 0;
        rx_hold_cycles = $urandom_range(60, 120);
      end
      for (int i = 0; i < n; i++) begin
        send_pixel(next_pixel(base_b, base_g, base_r));
      end
      rand_pixels += n;
      phase++;
    end

    rx_max_wait = 0;
    wait_idle();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d pixels and %0d items (%0d sharpened, %0d border), %0d writes.",
             sb.pixels, sb.results, sb.sharpened, sb.borders, cfg_writes);
    $display("Widths %0d..%0d, heights %0d..%0d, %0d long output stalls.",
             sb.w_min, sb.w_max, sb.h_min, sb.h_max, long_holds);
    if (sb.errors == 0 && sb.due_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("%0t: timeout with %0d items still due", $time, sb.due_pixels.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
